>>> hw/rtl/pshtu_pkg.sv
// ============================================================================
// Port socket hash table package
// Shared types, codes and the bucket mapping for the port-to-handle table.
// ============================================================================
package pshtu_pkg;

  localparam int unsigned BUCKETS = 64;
  localparam int unsigned WAYS = 4;

  localparam int unsigned BUCKET_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int unsigned WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam bit BUCKETS_POW2 = ((BUCKETS & (BUCKETS - 1)) == 0);

  localparam int unsigned RECIP_W = 33;
  localparam int unsigned PROD_W = 16 + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'(((64'd1 << 32) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS));

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_LOOKUP = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_DUPLICATE = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  typedef struct packed {
    op_e         operation;
    logic [15:0] port;
    logic [15:0] handle;
  } req_t;

  typedef struct packed {
    status_e     status;
    logic [15:0] found_handle;
  } rsp_t;

  typedef struct packed {
    logic [15:0] port;
    logic [15:0] handle;
  } entry_t;

  // The remainder by a constant bucket count is a mask for a power of two and
  // otherwise an exact multiplication by the rounded-up reciprocal.
  function automatic logic [BUCKET_W-1:0] bucket_of(logic [15:0] p);
    logic [PROD_W-1:0] prod;
    logic [15:0]       quo;
    logic [15:0]       rem;
    prod = '0;
    quo  = '0;
    if (BUCKETS_POW2) begin
      rem = p & 16'(BUCKETS - 1);
    end else begin
      prod = PROD_W'(p) * PROD_W'(RECIP);
      quo  = prod[32 +: 16];
      rem  = p - 16'(32'(quo) * 32'(BUCKETS));
    end
    return rem[BUCKET_W-1:0];
  endfunction

endpackage

>>> hw/rtl/port_socket_hash_table_unit.sv
// ============================================================================
// Port socket hash table unit
// Maps 16-bit port numbers to socket handles in a set-associative table.
// ============================================================================
// A request on the input channel inserts, deletes or looks up one port. The
// port selects a bucket, and the ways of that bucket are searched for a
// matching valid entry. Every request gives exactly one response with a
// status and, for a successful delete or lookup, the stored handle.
// Both channels use valid and ready. The bucket row is read from a
// synchronous memory in the cycle the request is accepted, and the response
// is registered from the busy state once the output register is free. The
// unit takes no new request until the current one has finished; the bucket
// memory is read for each request and written back after a successful insert. While a
// response waits on a stalled receiver the unit still accepts one more
// request; that request holds in the busy state until the output register
// is free. Reset clears all entry valid bits at once, so the table is empty
// and ready right after reset without any clearing pass.
// ============================================================================
module port_socket_hash_table_unit
  import pshtu_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  req_t in_req_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output rsp_t out_rsp_o
);

  typedef enum logic {
    S_IDLE,
    S_BUSY
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  rsp_t   out_rsp_q, out_rsp_d;
  req_t   req_q;
  logic [BUCKET_W-1:0] bucket_q;

  entry_t [WAYS-1:0] mem_q [BUCKETS];
  entry_t [WAYS-1:0] rd_row_q;
  entry_t [WAYS-1:0] wr_row;
  logic   [WAYS-1:0] valid_q [BUCKETS];

  logic                in_accept;
  logic                finish;
  logic [BUCKET_W-1:0] rd_bucket;
  logic [WAYS-1:0]     row_valid;
  logic [WAYS-1:0]     hit;
  logic [WAY_W-1:0]    hit_way;
  logic [WAY_W-1:0]    free_way;
  logic                set_en;
  logic                clr_en;
  status_e             status;
  logic [15:0]         found;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_accept   = in_valid_i && in_ready_o;
  assign finish      = (state_q == S_BUSY) && (!out_valid_q || out_ready_i);
  assign rd_bucket   = bucket_of(in_req_i.port);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  always_comb begin
    row_valid = valid_q[bucket_q];
    hit       = '0;
    hit_way   = '0;
    free_way  = '0;
    for (int w = 0; w < WAYS; w++) begin
      hit[w] = row_valid[w] && (rd_row_q[w].port == req_q.port);
    end
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (hit[w]) begin
        hit_way = WAY_W'(w);
      end
      if (!row_valid[w]) begin
        free_way = WAY_W'(w);
      end
    end

    status = ST_NOT_FOUND;
    found  = '0;
    set_en = 1'b0;
    clr_en = 1'b0;
    unique case (req_q.operation)
      OP_INSERT: begin
        if (|hit) begin
          status = ST_DUPLICATE;
        end else if (!(&row_valid)) begin
          status = ST_OK;
          set_en = 1'b1;
        end else begin
          status = ST_FULL;
        end
      end
      OP_DELETE: begin
        if (|hit) begin
          status = ST_OK;
          found  = rd_row_q[hit_way].handle;
          clr_en = 1'b1;
        end
      end
      OP_LOOKUP: begin
        if (|hit) begin
          status = ST_OK;
          found  = rd_row_q[hit_way].handle;
        end
      end
      default: begin
        status = ST_NOT_FOUND;
      end
    endcase

    wr_row = rd_row_q;
    wr_row[free_way].port   = req_q.port;
    wr_row[free_way].handle = req_q.handle;
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    out_rsp_d   = out_rsp_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          state_d = S_BUSY;
        end
      end
      S_BUSY: begin
        if (finish) begin
          state_d                = S_IDLE;
          out_valid_d            = 1'b1;
          out_rsp_d.status       = status;
          out_rsp_d.found_handle = found;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      out_rsp_q   <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      out_rsp_q   <= out_rsp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      req_q    <= in_req_i;
      bucket_q <= rd_bucket;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      rd_row_q <= mem_q[rd_bucket];
    end
    if (finish && set_en) begin
      mem_q[bucket_q] <= wr_row;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int b = 0; b < BUCKETS; b++) begin
        valid_q[b] <= '0;
      end
    end else if (finish) begin
      if (set_en) begin
        valid_q[bucket_q][free_way] <= 1'b1;
      end else if (clr_en) begin
        valid_q[bucket_q][hit_way] <= 1'b0;
      end
    end
  end

endmodule

>>> hw/rtl/pshtu_checker.sv
// ============================================================================
// Port socket hash table checker
// Port-level checks on the request and response channels of the table unit.
// ============================================================================
module pshtu_checker
  import pshtu_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input rsp_t out_rsp_o
);

  // A stalled response holds its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("Stalled response changed or dropped.");

  // Only a successful delete or lookup returns a handle.
  a_handle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_valid_o && (out_rsp_o.status != ST_OK) |-> out_rsp_o.found_handle == 16'd0)
    else $error("Handle returned with a failing status.");

  // The unit works on one request at a time.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
      in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("Request accepted while another is in progress.");

  // With a free output, the response is registered from the busy state.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
      in_valid_i && in_ready_o && (!out_valid_o || out_ready_i) |=> ##1 out_valid_o)
    else $error("Response missing two cycles after acceptance.");

endmodule

bind port_socket_hash_table_unit pshtu_checker u_pshtu_checker (.*);
